FILE: rtl/ir2d_pkg.sv
`default_nettype none
package ir2d_pkg;

  localparam int SAMPLE_W = 10;
  localparam int DIST_W   = 14;
  localparam int SUM_W    = 17;
  localparam int CNT_W    = 3;
  localparam int CFG_IDX_W = 3;

  // divider geometry: quotient bits, numerator and divisor widths
  localparam int Q_W     = DIST_W;
  localparam int NUM_W   = 29;
  localparam int DEN_W   = 18;
  localparam int HI_W    = NUM_W - Q_W;
  localparam int STEP_W  = 4;
  localparam int RAW_W   = 20;
  localparam int MUL_W   = 9;
  localparam int PROD_W  = SAMPLE_W + MUL_W;

  localparam int AVERAGE_COUNT = 5;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_OPEN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_NEAR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_NEAR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_FAR  = 3'd3;

  localparam logic [SAMPLE_W-1:0] RST_LONG_OPEN  = 10'd1000;
  localparam logic [SAMPLE_W-1:0] RST_LONG_NEAR  = 10'd573;
  localparam logic [SAMPLE_W-1:0] RST_SHORT_NEAR = 10'd819;
  localparam logic [SAMPLE_W-1:0] RST_SHORT_FAR  = 10'd204;

  localparam logic [MUL_W-1:0] LONG_MUL  = 9'd500;
  localparam logic [MUL_W-1:0] SHORT_MUL = 9'd50;
  localparam logic [RAW_W-1:0] LONG_OFF  = 20'd262144;
  localparam logic [RAW_W-1:0] SHORT_OFF = 20'd2048;
  localparam logic [NUM_W-1:0] LONG_NUM  = 29'd399769600;
  localparam logic [NUM_W-1:0] SHORT_NUM = 29'd16384000;

  localparam logic [DIST_W-1:0] DIST_MAX         = 14'd16383;
  localparam logic [DIST_W-1:0] LONG_OPEN_VALUE  = 14'd0;
  localparam logic [DIST_W-1:0] LONG_FAR_VALUE   = 14'd8000;
  localparam logic [DIST_W-1:0] SHORT_NEAR_VALUE = 14'd480;
  localparam logic [DIST_W-1:0] SHORT_FAR_VALUE  = 14'd2400;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/ir2d_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. Caller guarantees
// num >> Q_W < den, so the quotient fits Q_W bits.
module ir2d_div (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ir2d_pkg::div_req_t req,
  output ir2d_pkg::div_rsp_t     rsp
);

  logic [ir2d_pkg::DEN_W-1:0]  rem;
  logic [ir2d_pkg::DEN_W-1:0]  den;
  logic [ir2d_pkg::Q_W-1:0]    nq;     // numerator bits out, quotient bits in
  logic [ir2d_pkg::STEP_W-1:0] steps;
  logic                        done;

  logic [ir2d_pkg::DEN_W:0] trial;
  logic                     ge;

  assign trial = {rem, nq[ir2d_pkg::Q_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        steps <= ir2d_pkg::STEP_W'(ir2d_pkg::Q_W);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
        if (steps == ir2d_pkg::STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= {{(ir2d_pkg::DEN_W-ir2d_pkg::HI_W){1'b0}},
              req.num[ir2d_pkg::NUM_W-1:ir2d_pkg::Q_W]};
      nq  <= req.num[ir2d_pkg::Q_W-1:0];
      den <= req.den;
    end else if (steps != '0) begin
      if (ge) begin
        rem <= ir2d_pkg::DEN_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[ir2d_pkg::DEN_W-1:0];
      end
      nq <= {nq[ir2d_pkg::Q_W-2:0], ge};
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = nq;

endmodule
`default_nettype wire

FILE: rtl/ir_range_adc_to_distance.sv
`default_nettype none
// Flow: an accepted item passes CALC and PREP; the reciprocal then runs in DIV on the
// 14-step bit-serial divider unless the sample is clamped or saturated. FIN routes a
// short result to EMIT; a long sample that closes a group has the divider form the mean in AVG.
// Throughput: one item at a time; the next item is taken only once the last one is done,
// later while the output register is held off.
// Reset: thresholds back to their defaults, long sum and count cleared, output empty.
module ir_range_adc_to_distance (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [9:0] sample, rest zero
  input  wire logic        s_tuser,   // [0] kind: 0 long, 1 short
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [13:0] distance, rest zero
  output logic             m_tuser,   // [0] sensor: 0 long, 1 short
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for an item
  localparam logic [2:0] ST_CALC = 3'd1;  // thresholds and divisor
  localparam logic [2:0] ST_PREP = 3'd2;  // clamp, saturate or start divider
  localparam logic [2:0] ST_DIV  = 3'd3;  // reciprocal running
  localparam logic [2:0] ST_FIN  = 3'd4;  // route short out, fold long into sum
  localparam logic [2:0] ST_AVG  = 3'd5;  // mean of the group running
  localparam logic [2:0] ST_EMIT = 3'd6;  // hand result to output register

  logic [2:0] state;

  // thresholds
  logic [ir2d_pkg::SAMPLE_W-1:0] long_open;
  logic [ir2d_pkg::SAMPLE_W-1:0] long_near;
  logic [ir2d_pkg::SAMPLE_W-1:0] short_near;
  logic [ir2d_pkg::SAMPLE_W-1:0] short_far;

  // current item
  logic                          kind;
  logic [ir2d_pkg::SAMPLE_W-1:0] x;
  logic                          clamp;
  logic [ir2d_pkg::DIST_W-1:0]   clamp_val;
  logic [ir2d_pkg::RAW_W-1:0]    div_raw;   // signed divisor, two's complement
  logic [ir2d_pkg::DIST_W-1:0]   cur_dist;

  // long group
  logic [ir2d_pkg::SUM_W-1:0] long_sum;
  logic [ir2d_pkg::CNT_W-1:0] long_count;

  // output register
  logic                        out_valid;
  logic                        out_sensor;
  logic [ir2d_pkg::DIST_W-1:0] out_dist;

  ir2d_pkg::div_req_t div_req;
  ir2d_pkg::div_rsp_t div_rsp;

  ir2d_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  logic in_fire;
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;

  // divisor: k*x - offset, k and offset by sensor
  logic [ir2d_pkg::MUL_W-1:0]  mul_k;
  logic [ir2d_pkg::PROD_W-1:0] prod;
  logic [ir2d_pkg::RAW_W-1:0]  raw_calc;

  assign mul_k    = kind ? ir2d_pkg::SHORT_MUL : ir2d_pkg::LONG_MUL;
  assign prod     = {{ir2d_pkg::MUL_W{1'b0}}, x} *
                    {{ir2d_pkg::SAMPLE_W{1'b0}}, mul_k};
  assign raw_calc = {1'b0, prod} - (kind ? ir2d_pkg::SHORT_OFF : ir2d_pkg::LONG_OFF);

  // clamp decision; the first test of each pair wins on overlap
  logic                        clamp_calc;
  logic [ir2d_pkg::DIST_W-1:0] clamp_val_calc;

  always_comb begin
    clamp_calc     = 1'b0;
    clamp_val_calc = ir2d_pkg::LONG_OPEN_VALUE;
    if (kind) begin
      if (x >= short_near) begin
        clamp_calc     = 1'b1;
        clamp_val_calc = ir2d_pkg::SHORT_NEAR_VALUE;
      end else if (x <= short_far) begin
        clamp_calc     = 1'b1;
        clamp_val_calc = ir2d_pkg::SHORT_FAR_VALUE;
      end
    end else begin
      if (x >= long_open) begin
        clamp_calc     = 1'b1;
        clamp_val_calc = ir2d_pkg::LONG_OPEN_VALUE;
      end else if (x <= long_near) begin
        clamp_calc     = 1'b1;
        clamp_val_calc = ir2d_pkg::LONG_FAR_VALUE;
      end
    end
  end

  // saturation: divisor not positive, or quotient would exceed 14 bits,
  // which is exactly num >> 14 >= divisor
  logic [ir2d_pkg::NUM_W-1:0] num_sel;
  logic [ir2d_pkg::DEN_W-1:0] num_hi;
  logic                       div_nonpos;
  logic                       div_ovf;

  assign num_sel    = kind ? ir2d_pkg::SHORT_NUM : ir2d_pkg::LONG_NUM;
  assign num_hi     = {{(ir2d_pkg::DEN_W-ir2d_pkg::HI_W){1'b0}},
                       num_sel[ir2d_pkg::NUM_W-1:ir2d_pkg::Q_W]};
  assign div_nonpos = div_raw[ir2d_pkg::RAW_W-1] || (div_raw == '0);
  assign div_ovf    = num_hi >= div_raw[ir2d_pkg::DEN_W-1:0];

  // long group bookkeeping
  logic [ir2d_pkg::SUM_W-1:0] sum_next;
  logic [ir2d_pkg::CNT_W-1:0] count_next;
  logic                       group_full;

  assign sum_next   = long_sum + {{(ir2d_pkg::SUM_W-ir2d_pkg::DIST_W){1'b0}}, cur_dist};
  assign count_next = long_count + 1'b1;
  assign group_full = count_next >= ir2d_pkg::CNT_W'(ir2d_pkg::AVERAGE_COUNT);

  logic start_recip;
  logic start_avg;

  assign start_recip = (state == ST_PREP) && !clamp && !div_nonpos && !div_ovf;
  assign start_avg   = (state == ST_FIN) && !kind && group_full;

  always_comb begin
    div_req.start = start_recip || start_avg;
    if (start_avg) begin
      div_req.num = {{(ir2d_pkg::NUM_W-ir2d_pkg::SUM_W){1'b0}}, sum_next};
      div_req.den = ir2d_pkg::DEN_W'(ir2d_pkg::AVERAGE_COUNT);
    end else begin
      div_req.num = num_sel;
      div_req.den = div_raw[ir2d_pkg::DEN_W-1:0];
    end
  end

  logic out_load;
  assign out_load = (state == ST_EMIT) && (!out_valid || m_tready);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      long_sum   <= '0;
      long_count <= '0;
      out_valid  <= 1'b0;
      long_open  <= ir2d_pkg::RST_LONG_OPEN;
      long_near  <= ir2d_pkg::RST_LONG_NEAR;
      short_near <= ir2d_pkg::RST_SHORT_NEAR;
      short_far  <= ir2d_pkg::RST_SHORT_FAR;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ir2d_pkg::REG_LONG_OPEN:  long_open  <= cfg_data;
          ir2d_pkg::REG_LONG_NEAR:  long_near  <= cfg_data;
          ir2d_pkg::REG_SHORT_NEAR: short_near <= cfg_data;
          ir2d_pkg::REG_SHORT_FAR:  short_far  <= cfg_data;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) state <= ST_CALC;
        end
        ST_CALC: state <= ST_PREP;
        ST_PREP: begin
          state <= start_recip ? ST_DIV : ST_FIN;
        end
        ST_DIV: begin
          if (div_rsp.done) state <= ST_FIN;
        end
        ST_FIN: begin
          if (kind) begin
            state <= ST_EMIT;
          end else if (group_full) begin
            long_sum   <= '0;
            long_count <= '0;
            state      <= ST_AVG;
          end else begin
            long_sum   <= sum_next;
            long_count <= count_next;
            state      <= ST_IDLE;
          end
        end
        ST_AVG: begin
          if (div_rsp.done) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind <= s_tuser;
      x    <= s_tdata[ir2d_pkg::SAMPLE_W-1:0];
    end
    if (state == ST_CALC) begin
      clamp     <= clamp_calc;
      clamp_val <= clamp_val_calc;
      div_raw   <= raw_calc;
    end
    if (state == ST_PREP) begin
      cur_dist <= clamp ? clamp_val : ir2d_pkg::DIST_MAX;
    end
    if ((state == ST_DIV || state == ST_AVG) && div_rsp.done) begin
      cur_dist <= div_rsp.quo;
    end
    if (out_load) begin
      out_sensor <= kind;
      out_dist   <= cur_dist;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_sensor;
  assign m_tdata  = {{(16-ir2d_pkg::DIST_W){1'b0}}, out_dist};

endmodule
`default_nettype wire

FILE: bench/ir_range_adc_to_distance_test.sv
`timescale 1ns / 1ps
module ir_range_adc_to_distance_test;

  // sensor tags on tuser
  localparam logic KIND_LONG  = 1'b0;
  localparam logic KIND_SHORT = 1'b1;

  // unmapped register indexes, writes there must be dropped
  localparam logic [ir2d_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [ir2d_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int N_REGS = 4;

  // linearization constants, distance in 1/16 cm
  localparam longint LONG_RECIP_NUM  = 399769600;
  localparam longint LONG_SLOPE      = 500;
  localparam longint LONG_OFFSET     = 262144;
  localparam longint SHORT_RECIP_NUM = 16384000;
  localparam longint SHORT_SLOPE     = 50;
  localparam longint SHORT_OFFSET    = 2048;
  localparam longint DIST_SAT        = 16383;
  localparam logic [ir2d_pkg::DIST_W-1:0] DIST_OPEN  = 14'd0;
  localparam logic [ir2d_pkg::DIST_W-1:0] DIST_500CM = 14'd8000;
  localparam logic [ir2d_pkg::DIST_W-1:0] DIST_30CM  = 14'd480;
  localparam logic [ir2d_pkg::DIST_W-1:0] DIST_150CM = 14'd2400;
  localparam logic [ir2d_pkg::DIST_W-1:0] DIST_TOP   = 14'd16383;

  // run shape
  localparam int SETTLE_CYCLES   = 60;    // covers the worst path through reciprocal and mean, plus margin
  localparam int STALL_LIMIT     = 3000;  // cycles with no item moving on either side
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int MAX_REPORTS     = 40;

  // directed table rows
  localparam logic [1:0] ROW_CFG     = 2'd0;
  localparam logic [1:0] ROW_PREDICT = 2'd1;
  localparam logic [1:0] ROW_TYPED   = 2'd2;

  typedef struct packed {
    logic [1:0]                     what;
    logic [ir2d_pkg::CFG_IDX_W-1:0] index;  // register index of a write
    logic                           kind;
    logic [ir2d_pkg::SAMPLE_W-1:0]  value;  // sample, or register data
    logic [ir2d_pkg::DIST_W-1:0]    want;   // typed-in expectation
  } row_t;

  typedef struct packed {
    logic                        sensor;
    logic [ir2d_pkg::DIST_W-1:0] distance;
  } range_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CADENCE, RX_SPARSE} rx_mode_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [15:0]                    s_tdata   = '0;  // [9:0] sample, rest zero
  logic                           s_tuser   = 1'b0;  // [0] kind: 0 long, 1 short
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [15:0]                    m_tdata;  // [13:0] distance, rest zero
  logic                           m_tuser;  // [0] sensor: 0 long, 1 short
  logic                           cfg_we    = 1'b0;
  logic [ir2d_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ir2d_pkg::SAMPLE_W-1:0]  cfg_data  = '0;

  ir_range_adc_to_distance u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // shadow of the block: thresholds and the long-range averaging group
  logic [ir2d_pkg::SAMPLE_W-1:0] threshold   [N_REGS];
  logic [ir2d_pkg::SAMPLE_W-1:0] reg_default [N_REGS];
  logic [ir2d_pkg::SUM_W-1:0]    long_total;
  logic [ir2d_pkg::CNT_W-1:0]    long_seen;

  range_t dist_expected[$];  // distances still owed by the block, oldest first

  int  errors       = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  cfg_writes   = 0;
  int  burst_left   = 0;
  int  idle_cycles  = 0;
  bit  hold_request = 1'b0;
  bit  hold_done    = 1'b0;

  // floored reciprocal; non-positive divisor and overflow both pin to the top
  function automatic logic [ir2d_pkg::DIST_W-1:0] recip_sat(longint num, longint den);
    longint q;
    if (den <= 0) return DIST_TOP;
    q = num / den;
    return (q > DIST_SAT) ? DIST_TOP : q[ir2d_pkg::DIST_W-1:0];
  endfunction

  // per-sample conversion; open/near tests first so overlapping thresholds resolve
  function automatic logic [ir2d_pkg::DIST_W-1:0] convert_sample(
      logic kind, logic [ir2d_pkg::SAMPLE_W-1:0] x);
    longint xs;
    xs = x;
    if (kind == KIND_SHORT) begin
      if (x >= threshold[ir2d_pkg::REG_SHORT_NEAR]) return DIST_30CM;
      if (x <= threshold[ir2d_pkg::REG_SHORT_FAR]) return DIST_150CM;
      return recip_sat(SHORT_RECIP_NUM, xs * SHORT_SLOPE - SHORT_OFFSET);
    end
    if (x >= threshold[ir2d_pkg::REG_LONG_OPEN]) return DIST_OPEN;
    if (x <= threshold[ir2d_pkg::REG_LONG_NEAR]) return DIST_500CM;
    return recip_sat(LONG_RECIP_NUM, xs * LONG_SLOPE - LONG_OFFSET);
  endfunction

  // short: emit now; long: accumulate, emit the floored mean on every fifth
  task automatic predict_range(input logic kind, input logic [ir2d_pkg::SAMPLE_W-1:0] x,
                               output bit produced, output range_t res);
    logic [ir2d_pkg::DIST_W-1:0] d;
    d = convert_sample(kind, x);
    produced = 1'b0;
    res = '0;
    if (kind == KIND_SHORT) begin
      produced = 1'b1;
      res.sensor = KIND_SHORT;
      res.distance = d;
    end else begin
      long_total = long_total + ir2d_pkg::SUM_W'(d);
      long_seen = long_seen + 1'b1;
      if (long_seen >= ir2d_pkg::AVERAGE_COUNT) begin
        produced = 1'b1;
        res.sensor = KIND_LONG;
        res.distance = ir2d_pkg::DIST_W'(long_total / ir2d_pkg::AVERAGE_COUNT);
        long_total = '0;
        long_seen = '0;
      end
    end
  endtask

  function automatic row_t item_row(logic kind, logic [ir2d_pkg::SAMPLE_W-1:0] x);
    return '{what: ROW_PREDICT, index: '0, kind: kind, value: x, want: '0};
  endfunction

  function automatic row_t typed_row(logic kind, logic [ir2d_pkg::SAMPLE_W-1:0] x,
                                     logic [ir2d_pkg::DIST_W-1:0] d);
    return '{what: ROW_TYPED, index: '0, kind: kind, value: x, want: d};
  endfunction

  function automatic row_t cfg_row(logic [ir2d_pkg::CFG_IDX_W-1:0] idx,
                                   logic [ir2d_pkg::SAMPLE_W-1:0] v);
    return '{what: ROW_CFG, index: idx, kind: 1'b0, value: v, want: '0};
  endfunction

  // random samples: half around and between the active thresholds, rest uniform or at the ends
  function automatic logic [ir2d_pkg::SAMPLE_W-1:0] pick_sample(logic kind);
    int lo, hi, pick, jitter;
    lo = (kind == KIND_SHORT) ? threshold[ir2d_pkg::REG_SHORT_FAR]
                              : threshold[ir2d_pkg::REG_LONG_NEAR];
    hi = (kind == KIND_SHORT) ? threshold[ir2d_pkg::REG_SHORT_NEAR]
                              : threshold[ir2d_pkg::REG_LONG_OPEN];
    jitter = $urandom_range(0, 6);
    case ($urandom_range(0, 7))
      0, 1, 2: pick = $urandom_range(0, 1023);
      3, 4:    pick = ($urandom_range(0, 1) ? lo : hi) + jitter - 3;
      5, 6:    pick = (lo < hi) ? $urandom_range(lo, hi) : $urandom_range(0, 1023);
      default: pick = $urandom_range(0, 1) ? 0 : 1023;
    endcase
    if (pick < 0) pick = 0;
    if (pick > 1023) pick = 1023;
    return pick[ir2d_pkg::SAMPLE_W-1:0];
  endfunction

  // one config write; the shadow follows once the edge has taken it
  task automatic write_reg(input logic [ir2d_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ir2d_pkg::SAMPLE_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < N_REGS) threshold[idx] = v;
    cfg_writes++;
    @(posedge clk);
  endtask

  // offer one item, wait for the handshake, book the expected distance.
  // tvalid stays up inside a burst and drops for a random gap after it.
  task automatic send_item(input logic kind, input logic [ir2d_pkg::SAMPLE_W-1:0] x,
                           input bit typed, input logic [ir2d_pkg::DIST_W-1:0] typed_dist);
    bit     produced;
    range_t res;
    if (burst_left == 0) burst_left = $urandom_range(1, 40);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {6'b0, x};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    predict_range(kind, x, produced, res);
    if (typed) dist_expected.push_back('{sensor: kind, distance: typed_dist});
    else if (produced) dist_expected.push_back(res);
    burst_left--;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  // stop offering, let every owed distance come out, then cover the
  // tail of a long sample that closes no group
  task automatic settle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (dist_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: segments of its own stall pattern, one long hold-off on request
  initial begin : receiver
    rx_mode_t mode;
    int       span;
    int       tick;
    while (rst) @(posedge clk);
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      for (tick = 0; tick < span; tick++) begin
        if (hold_request && !hold_done) begin
          // back-pressure while the sender keeps offering: block fills, tready drops
          m_tready <= 1'b0;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          RX_OPEN:    m_tready <= 1'b1;
          RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
          RX_CADENCE: m_tready <= ((tick % 4) != 3);
          default:    m_tready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // scoreboard and watchdog; values read here are the pre-edge ones
  always @(posedge clk) begin : result_check
    range_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (dist_expected.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none, got sensor %0d distance %0d",
                     $time, m_tuser, m_tdata);
        end else begin
          want = dist_expected.pop_front();
          if (m_tuser !== want.sensor) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: sensor mismatch, expected %0d, got %0d",
                       $time, want.sensor, m_tuser);
          end
          if (m_tdata !== {2'b00, want.distance}) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: distance mismatch, expected %0d, got %0d",
                       $time, want.distance, m_tdata);
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, nothing moved for %0d cycles, %0d distances owed",
                 $time, STALL_LIMIT, dist_expected.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    row_t                           plan[$];
    logic [ir2d_pkg::CFG_IDX_W-1:0] idx;
    logic [ir2d_pkg::SAMPLE_W-1:0]  v;
    logic                           kind;
    int                             phase;
    int                             n;

    reg_default[ir2d_pkg::REG_LONG_OPEN]  = ir2d_pkg::RST_LONG_OPEN;
    reg_default[ir2d_pkg::REG_LONG_NEAR]  = ir2d_pkg::RST_LONG_NEAR;
    reg_default[ir2d_pkg::REG_SHORT_NEAR] = ir2d_pkg::RST_SHORT_NEAR;
    reg_default[ir2d_pkg::REG_SHORT_FAR]  = ir2d_pkg::RST_SHORT_FAR;
    threshold = reg_default;
    long_total = '0;
    long_seen = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset thresholds: short clamps at both ends and at the thresholds,
    // one short sample dropped into the middle of a long group
    plan.push_back(typed_row(KIND_SHORT, 10'd1023, DIST_30CM));
    plan.push_back(typed_row(KIND_SHORT, 10'd0, DIST_150CM));
    plan.push_back(typed_row(KIND_SHORT, 10'd819, DIST_30CM));
    plan.push_back(typed_row(KIND_SHORT, 10'd204, DIST_150CM));
    plan.push_back(item_row(KIND_LONG, 10'd1023));
    plan.push_back(item_row(KIND_LONG, 10'd0));
    plan.push_back(item_row(KIND_SHORT, 10'd500));
    plan.push_back(item_row(KIND_LONG, 10'd573));
    plan.push_back(item_row(KIND_LONG, 10'd574));
    plan.push_back(item_row(KIND_LONG, 10'd999));
    // near/far at zero: negative divisors and huge quotients saturate;
    // unmapped indexes must leave the thresholds alone
    plan.push_back(cfg_row(ir2d_pkg::REG_LONG_NEAR, 10'd0));
    plan.push_back(cfg_row(ir2d_pkg::REG_SHORT_FAR, 10'd0));
    plan.push_back(cfg_row(REG_SPARE_LO, 10'd77));
    plan.push_back(cfg_row(REG_SPARE_HI, 10'd1023));
    plan.push_back(item_row(KIND_LONG, 10'd524));
    plan.push_back(item_row(KIND_LONG, 10'd525));
    plan.push_back(item_row(KIND_LONG, 10'd1));
    plan.push_back(item_row(KIND_LONG, 10'd0));
    plan.push_back(item_row(KIND_LONG, 10'd1023));
    plan.push_back(typed_row(KIND_SHORT, 10'd40, DIST_TOP));
    plan.push_back(typed_row(KIND_SHORT, 10'd41, DIST_TOP));
    plan.push_back(typed_row(KIND_SHORT, 10'd0, DIST_150CM));
    // crossed thresholds: open beats near for long, near beats far for short
    plan.push_back(cfg_row(ir2d_pkg::REG_LONG_OPEN, 10'd100));
    plan.push_back(cfg_row(ir2d_pkg::REG_LONG_NEAR, 10'd200));
    plan.push_back(cfg_row(ir2d_pkg::REG_SHORT_NEAR, 10'd100));
    plan.push_back(cfg_row(ir2d_pkg::REG_SHORT_FAR, 10'd200));
    plan.push_back(typed_row(KIND_SHORT, 10'd150, DIST_30CM));
    plan.push_back(item_row(KIND_LONG, 10'd150));
    plan.push_back(item_row(KIND_LONG, 10'd150));
    plan.push_back(item_row(KIND_LONG, 10'd150));
    plan.push_back(item_row(KIND_LONG, 10'd150));
    plan.push_back(typed_row(KIND_LONG, 10'd150, DIST_OPEN));

    foreach (plan[i]) begin
      if (plan[i].what == ROW_CFG) begin
        if (i > 0 && plan[i-1].what != ROW_CFG) settle();
        write_reg(plan[i].index, plan[i].value);
      end else begin
        send_item(plan[i].kind, plan[i].value, plan[i].what == ROW_TYPED, plan[i].want);
      end
    end

    // random part: defaults, all-max, all-zero, then mixed settings
    for (phase = 0; phase < N_PHASES; phase++) begin
      settle();
      for (idx = ir2d_pkg::REG_LONG_OPEN; idx <= ir2d_pkg::REG_SHORT_FAR; idx++) begin
        case (phase)
          0: v = reg_default[idx];
          1: v = 10'd1023;
          2: v = 10'd0;
          default: begin
            case ($urandom_range(0, 4))
              0: v = 10'd0;
              1: v = 10'd1023;
              2: v = reg_default[idx];
              default: v = ir2d_pkg::SAMPLE_W'($urandom_range(0, 1023));
            endcase
          end
        endcase
        write_reg(idx, v);
      end
      write_reg(ir2d_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                ir2d_pkg::SAMPLE_W'($urandom_range(0, 1023)));
      if (phase == 3) hold_request = 1'b1;
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = 1'($urandom_range(0, 1));
        send_item(kind, pick_sample(kind), 1'b0, '0);
      end
    end
    settle();

    $display("Run covered %0d samples over %0d threshold settings (%0d register writes),",
             items_sent, N_PHASES + 3, cfg_writes);
    $display("%0d distances checked, %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ir2d_pkg.sv
rtl/ir2d_div.sv
rtl/ir_range_adc_to_distance.sv
bench/ir_range_adc_to_distance_test.sv
